/* design/step_ramp_pkg.sv */
// Shared types and constants of the trapezoidal stepper ramp generator.
// Used by step_ramp_ctrl, step_ramp_dp and stepper_trapezoid_ramp; depends on nothing.
`timescale 1ns / 1ps

package step_ramp_pkg;

  // Stream widths: input fields pack into 61 bits, result fields into 40 bits.
  localparam int unsigned IN_TDATA_W  = 64;
  localparam int unsigned OUT_TDATA_W = 40;

  // Action codes carried by an input item.
  localparam logic [2:0] ACT_LOAD    = 3'd0;
  localparam logic [2:0] ACT_START   = 3'd1;
  localparam logic [2:0] ACT_STOP    = 3'd2;
  localparam logic [2:0] ACT_TICK    = 3'd3;
  localparam logic [2:0] ACT_DISABLE = 3'd4;

  // Ramp phase codes.
  localparam logic [2:0] PH_IDLE   = 3'd0;
  localparam logic [2:0] PH_ACCEL  = 3'd1;
  localparam logic [2:0] PH_CRUISE = 3'd2;
  localparam logic [2:0] PH_DECEL  = 3'd3;
  localparam logic [2:0] PH_LAST   = 3'd4;

  // The tick timer counts up to overflow, so the preload is this minus the period.
  localparam logic [15:0] RELOAD_BASE = 16'hFFFF;

  // Datapath operations issued by the controller, one per cycle.
  typedef enum logic [3:0] {
    DP_NOP,
    DP_LOAD,
    DP_START_INIT,
    DP_SUM_RD,
    DP_SUM_END,
    DP_START_FIN,
    DP_STOP,
    DP_DISABLE,
    DP_TICK_END,
    DP_TICK_RDA,
    DP_TICK_RDB,
    DP_TICK_UPD,
    DP_TICK_FIN
  } dp_op_e;

  typedef struct packed {
    logic   latch;
    dp_op_e op;
  } dp_cmd_t;

  typedef struct packed {
    logic [2:0] action;
    logic       running;
    logic       same_pos;
    logic       moving;
    logic       sum_last;
  } dp_status_t;

  // First member is the most significant, so action lands in the lowest bits.
  typedef struct packed {
    logic [15:0] entry_steps;
    logic [15:0] entry_period;
    logic [4:0]  entry_index;
    logic [4:0]  speed_index;
    logic [15:0] target_position;
    logic [2:0]  action;
  } in_item_t;

  typedef struct packed {
    logic [2:0]  phase;
    logic [15:0] position;
    logic [15:0] timer_reload;
    logic        timer_enabled;
    logic        busy_res;
    logic        driver_enabled;
    logic        direction;
    logic        step_level;
  } result_t;

endpackage

/* design/stepper_trapezoid_ramp.sv */
// Top level of the trapezoidal stepper ramp generator: stream ports and result register.
// Depends on step_ramp_pkg, step_ramp_ctrl and step_ramp_dp.
`timescale 1ns / 1ps

// Usage
// Each input item on the slave stream carries one action: load a speed table entry, start a
// move, stop, timer tick or disable. Every accepted item produces exactly one result item on
// the master stream, a snapshot of the axis state after the action: step pin, direction,
// driver and timer enables, busy flag, timer preload value, position and ramp phase.
// Items are handled one at a time. Load, stop, disable, a tick with no move in the accel,
// cruise or decel phase, an unused action code, and a refused start (axis busy or already
// at the target) go from dispatch straight to the output register. A tick during a move
// first makes two reads of the steps table and one of the period table. A start that
// launches a move reads the steps table once per level up to the top, one entry a cycle, to sum
// the ramp length. tready rises again in the same cycle that the result enters the output
// register. The result sits in an output register, so the next item is accepted while it
// waits; if the receiver stalls, that next item completes its work and then holds until the
// register frees. Reset (asynchronous, active low) returns the axis to idle at position zero
// with the step pin and direction high and the driver off. The speed tables are not cleared;
// entries must be loaded before a move uses them.

module stepper_trapezoid_ramp #(
  parameter int unsigned TABLE_DEPTH = 20
) (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   s_axis_tvalid,
  output logic                                   s_axis_tready,
  // action[2:0], target_position[18:3], speed_index[23:19], entry_index[28:24],
  // entry_period[44:29], entry_steps[60:45], zero fill [63:61]
  input  logic [step_ramp_pkg::IN_TDATA_W-1:0]   s_axis_tdata,
  output logic                                   m_axis_tvalid,
  input  logic                                   m_axis_tready,
  // step_level[0], direction[1], driver_enabled[2], busy_res[3], timer_enabled[4],
  // timer_reload[20:5], position[36:21], phase[39:37]
  output logic [step_ramp_pkg::OUT_TDATA_W-1:0]  m_axis_tdata
);
  import step_ramp_pkg::*;

  in_item_t   in_item;
  dp_cmd_t    cmd;
  dp_status_t status;
  result_t    result;
  logic       out_free, emit;
  logic       m_valid_q;
  result_t    m_data_q;

  // The upper fill bits of tdata carry nothing.
  assign in_item = s_axis_tdata[$bits(in_item_t)-1:0];

  // The output register is free when empty or being drained in this cycle.
  assign out_free = !m_valid_q || m_axis_tready;

  step_ramp_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .status_i   (status),
    .cmd_o      (cmd),
    .out_free_i (out_free),
    .emit_o     (emit)
  );

  step_ramp_dp #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_dp (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .item_i   (in_item),
    .cmd_i    (cmd),
    .status_o (status),
    .result_o (result)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
    end else if (emit) begin
      m_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      m_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) m_data_q <= result;
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = OUT_TDATA_W'(m_data_q);

  // A result is never produced in the cycle an item is accepted.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready) |-> !emit)
    else $error("result emitted while accepting an item");

  // The controller only loads the output register when it can take the result.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    emit |-> (!m_valid_q || m_axis_tready))
    else $error("result register overwritten while full");

  // After an item is accepted the block is busy with it and takes no item in the next cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
    else $error("second item accepted back to back");

  // Reported phase stays within the defined codes.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_data_q.phase <= PH_LAST))
    else $error("undefined ramp phase reported");

endmodule

/* design/step_ramp_ctrl.sv */
// Sequencing state machine of the stepper ramp generator.
// Depends on step_ramp_pkg; drives step_ramp_dp through command and status structs.
`timescale 1ns / 1ps

module step_ramp_ctrl (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid_i,
  output logic                     in_ready_o,
  input  step_ramp_pkg::dp_status_t status_i,
  output step_ramp_pkg::dp_cmd_t    cmd_o,
  input  logic                     out_free_i,
  output logic                     emit_o
);
  import step_ramp_pkg::*;

  localparam logic [3:0] ST_IDLE      = 4'd0;
  localparam logic [3:0] ST_DISPATCH  = 4'd1;
  localparam logic [3:0] ST_SUM       = 4'd2;
  localparam logic [3:0] ST_SUM_END   = 4'd3;
  localparam logic [3:0] ST_START_FIN = 4'd4;
  localparam logic [3:0] ST_TICK_B    = 4'd5;
  localparam logic [3:0] ST_TICK_UPD  = 4'd6;
  localparam logic [3:0] ST_TICK_FIN  = 4'd7;
  localparam logic [3:0] ST_EMIT      = 4'd8;

  logic [3:0] state_q, state_d;

  always_comb begin
    state_d     = state_q;
    cmd_o.latch = 1'b0;
    cmd_o.op    = DP_NOP;
    in_ready_o  = 1'b0;
    emit_o      = 1'b0;
    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.latch = 1'b1;
          state_d     = ST_DISPATCH;
        end
      end
      ST_DISPATCH: begin
        state_d = ST_EMIT;
        case (status_i.action)
          ACT_LOAD: cmd_o.op = DP_LOAD;
          ACT_START: begin
            cmd_o.op = DP_START_INIT;
            if (!status_i.running && !status_i.same_pos) state_d = ST_SUM;
          end
          ACT_STOP: cmd_o.op = DP_STOP;
          ACT_TICK: begin
            if (status_i.moving) begin
              cmd_o.op = DP_TICK_RDA;
              state_d  = ST_TICK_B;
            end else begin
              cmd_o.op = DP_TICK_END;
            end
          end
          ACT_DISABLE: cmd_o.op = DP_DISABLE;
          default: cmd_o.op = DP_NOP;
        endcase
      end
      ST_SUM: begin
        cmd_o.op = DP_SUM_RD;
        if (status_i.sum_last) state_d = ST_SUM_END;
      end
      ST_SUM_END: begin
        cmd_o.op = DP_SUM_END;
        state_d  = ST_START_FIN;
      end
      ST_START_FIN: begin
        cmd_o.op = DP_START_FIN;
        state_d  = ST_EMIT;
      end
      ST_TICK_B: begin
        cmd_o.op = DP_TICK_RDB;
        state_d  = ST_TICK_UPD;
      end
      ST_TICK_UPD: begin
        cmd_o.op = DP_TICK_UPD;
        state_d  = ST_TICK_FIN;
      end
      ST_TICK_FIN: begin
        cmd_o.op = DP_TICK_FIN;
        state_d  = ST_EMIT;
      end
      ST_EMIT: begin
        if (out_free_i) begin
          emit_o  = 1'b1;
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

/* design/step_ramp_dp.sv */
// Datapath of the stepper ramp generator: speed table memories and the move state.
// Depends on step_ramp_pkg; executes one operation per cycle from step_ramp_ctrl.
`timescale 1ns / 1ps

module step_ramp_dp #(
  parameter int unsigned TABLE_DEPTH = 20
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  step_ramp_pkg::in_item_t   item_i,
  input  step_ramp_pkg::dp_cmd_t    cmd_i,
  output step_ramp_pkg::dp_status_t status_o,
  output step_ramp_pkg::result_t    result_o
);
  import step_ramp_pkg::*;

  localparam int unsigned IW = $clog2(TABLE_DEPTH);
  localparam logic [IW-1:0] LAST_LVL = IW'(TABLE_DEPTH - 1);
  localparam logic [IW-1:0] TOP_RST  = (TABLE_DEPTH - 1 < 19) ? IW'(TABLE_DEPTH - 1) : IW'(19);

  logic [15:0] period_mem [TABLE_DEPTH];
  logic [15:0] steps_mem  [TABLE_DEPTH];

  in_item_t           in_q;
  logic [15:0]        st_rdata_q, pt_rdata_q, a_q;
  logic               st_rd_en, pt_rd_en, wr_en;
  logic [IW-1:0]      st_rd_addr, pt_rd_addr;

  logic [IW-1:0]      lvl_q, lvl_d, top_q, top_d, j_q, j_d;
  logic [15:0]        sc_q, sc_d, mark_q, mark_d, decel_q, decel_d;
  logic [15:0]        mlen_q, mlen_d, mid_q, mid_d, rtotal_q, rtotal_d, reload_q, reload_d;
  logic signed [15:0] pos_q, pos_d;
  logic [2:0]         phase_q, phase_d;
  logic               half_q, half_d, sign_q, sign_d, pin_q, pin_d, dir_q, dir_d;
  logic               en_q, en_d, tmr_q, tmr_d, run_q, run_d, pend_q, pend_d;

  logic [IW-1:0]      lvl_up, lvl_dn;
  logic               is_climb, long_move, same_pos, entry_ok;
  logic signed [15:0] tgt;
  logic [15:0]        decel_mark;

  assign tgt        = $signed(in_q.target_position);
  assign lvl_up     = (lvl_q == LAST_LVL) ? lvl_q : lvl_q + 1'b1;
  assign lvl_dn     = (lvl_q == '0) ? '0 : lvl_q - 1'b1;
  assign is_climb   = (phase_q == PH_ACCEL) || (phase_q == PH_CRUISE);
  assign long_move  = {1'b0, mlen_q} > {rtotal_q, 1'b0};
  assign same_pos   = (tgt == pos_q);
  assign decel_mark = decel_q + a_q;
  assign entry_ok   = {27'd0, in_q.entry_index} < 32'(TABLE_DEPTH);
  assign wr_en      = (cmd_i.op == DP_LOAD) && entry_ok;

  // Read port selection for both tables.
  always_comb begin
    st_rd_en   = 1'b0;
    st_rd_addr = '0;
    pt_rd_en   = 1'b0;
    pt_rd_addr = '0;
    case (cmd_i.op)
      DP_SUM_RD: begin
        st_rd_en   = 1'b1;
        st_rd_addr = j_q;
      end
      DP_TICK_RDA: begin
        st_rd_en = 1'b1;
        if (is_climb) st_rd_addr = (lvl_q == '0) ? '0 : lvl_up;
        else          st_rd_addr = lvl_q;
      end
      DP_TICK_RDB: begin
        st_rd_en   = 1'b1;
        st_rd_addr = is_climb ? IW'(1) : lvl_dn;
      end
      DP_SUM_END: pt_rd_en = 1'b1;
      DP_TICK_UPD: begin
        pt_rd_en   = 1'b1;
        pt_rd_addr = lvl_d;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      period_mem[IW'(in_q.entry_index)] <= in_q.entry_period;
      steps_mem[IW'(in_q.entry_index)]  <= in_q.entry_steps;
    end
    if (st_rd_en) st_rdata_q <= steps_mem[st_rd_addr];
    if (pt_rd_en) pt_rdata_q <= period_mem[pt_rd_addr];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.latch) in_q <= item_i;
    if (cmd_i.op == DP_TICK_RDB) a_q <= st_rdata_q;
  end

  always_comb begin
    lvl_d    = lvl_q;
    top_d    = top_q;
    j_d      = j_q;
    sc_d     = sc_q;
    mark_d   = mark_q;
    decel_d  = decel_q;
    mlen_d   = mlen_q;
    mid_d    = mid_q;
    rtotal_d = rtotal_q;
    reload_d = reload_q;
    pos_d    = pos_q;
    phase_d  = phase_q;
    half_d   = half_q;
    sign_d   = sign_q;
    pin_d    = pin_q;
    dir_d    = dir_q;
    en_d     = en_q;
    tmr_d    = tmr_q;
    run_d    = run_q;
    pend_d   = pend_q;
    case (cmd_i.op)
      DP_START_INIT: begin
        top_d    = (int'(in_q.speed_index) > TABLE_DEPTH - 1) ? LAST_LVL
                                                               : IW'(in_q.speed_index);
        rtotal_d = '0;
        j_d      = '0;
        pend_d   = 1'b0;
        if (!run_q && !same_pos) begin
          if (tgt < pos_q) begin
            dir_d  = 1'b1;
            sign_d = 1'b1;
            mlen_d = $unsigned(pos_q - tgt);
          end else begin
            dir_d  = 1'b0;
            sign_d = 1'b0;
            mlen_d = $unsigned(tgt - pos_q);
          end
        end
      end
      DP_SUM_RD: begin
        if (pend_q) rtotal_d = rtotal_q + st_rdata_q;
        pend_d = 1'b1;
        j_d    = j_q + 1'b1;
      end
      DP_SUM_END: begin
        rtotal_d = rtotal_q + st_rdata_q;
        pend_d   = 1'b0;
      end
      DP_START_FIN: begin
        if (long_move) begin
          mid_d   = rtotal_q;
          decel_d = mlen_q - rtotal_q;
        end else begin
          mid_d   = (mlen_q - 16'd1) >> 1;
          decel_d = (mlen_q - 16'd1) >> 1;
        end
        sc_d     = '0;
        mark_d   = '0;
        lvl_d    = '0;
        phase_d  = PH_ACCEL;
        run_d    = 1'b1;
        en_d     = 1'b1;
        tmr_d    = 1'b1;
        reload_d = RELOAD_BASE - pt_rdata_q;
      end
      DP_STOP: begin
        sc_d    = decel_q;
        phase_d = PH_DECEL;
      end
      DP_DISABLE: begin
        en_d  = 1'b0;
        tmr_d = 1'b0;
      end
      DP_TICK_END: begin
        phase_d = PH_IDLE;
        tmr_d   = 1'b0;
        run_d   = 1'b0;
      end
      DP_TICK_UPD: begin
        // a_q holds the first table read, st_rdata_q the second.
        pin_d  = ~pin_q;
        half_d = ~half_q;
        if (is_climb) begin
          if (lvl_q == '0) begin
            if (sc_q == a_q) begin
              mark_d = mark_q + a_q + st_rdata_q;
              lvl_d  = IW'(1);
            end
          end else if (lvl_q != top_q) begin
            if (sc_q == mark_q) begin
              lvl_d  = lvl_up;
              mark_d = mark_q + a_q;
            end
          end
          if (phase_q == PH_ACCEL) begin
            if (sc_q == mid_q) phase_d = long_move ? PH_CRUISE : PH_DECEL;
          end else if (sc_q == decel_q) begin
            phase_d = PH_DECEL;
          end
        end else begin
          if ((lvl_q == top_q) && (lvl_q != '0)) begin
            if (sc_q == decel_mark) begin
              mark_d = decel_mark + st_rdata_q;
              lvl_d  = lvl_dn;
            end
          end else if (lvl_q != '0) begin
            if (sc_q == mark_q) begin
              lvl_d  = lvl_dn;
              mark_d = mark_q + st_rdata_q;
            end
          end
          if (sc_q == mlen_q) phase_d = PH_LAST;
        end
        // A full step completes, advancing position and step count, on the pin edges made while half_q is clear.
        if (!half_q) begin
          pos_d = sign_q ? pos_q - 16'sd1 : pos_q + 16'sd1;
          sc_d  = sc_q + 16'd1;
        end
      end
      DP_TICK_FIN: reload_d = RELOAD_BASE - pt_rdata_q;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lvl_q    <= '0;
      top_q    <= TOP_RST;
      j_q      <= '0;
      sc_q     <= '0;
      mark_q   <= '0;
      decel_q  <= '0;
      mlen_q   <= '0;
      mid_q    <= '0;
      rtotal_q <= '0;
      reload_q <= '0;
      pos_q    <= '0;
      phase_q  <= PH_IDLE;
      half_q   <= 1'b0;
      sign_q   <= 1'b0;
      pin_q    <= 1'b1;
      dir_q    <= 1'b1;
      en_q     <= 1'b0;
      tmr_q    <= 1'b0;
      run_q    <= 1'b0;
      pend_q   <= 1'b0;
    end else begin
      lvl_q    <= lvl_d;
      top_q    <= top_d;
      j_q      <= j_d;
      sc_q     <= sc_d;
      mark_q   <= mark_d;
      decel_q  <= decel_d;
      mlen_q   <= mlen_d;
      mid_q    <= mid_d;
      rtotal_q <= rtotal_d;
      reload_q <= reload_d;
      pos_q    <= pos_d;
      phase_q  <= phase_d;
      half_q   <= half_d;
      sign_q   <= sign_d;
      pin_q    <= pin_d;
      dir_q    <= dir_d;
      en_q     <= en_d;
      tmr_q    <= tmr_d;
      run_q    <= run_d;
      pend_q   <= pend_d;
    end
  end

  assign status_o.action   = in_q.action;
  assign status_o.running  = run_q;
  assign status_o.same_pos = same_pos;
  assign status_o.moving   = is_climb || (phase_q == PH_DECEL);
  assign status_o.sum_last = (j_q == top_q);

  assign result_o.phase          = phase_q;
  assign result_o.position       = pos_q;
  assign result_o.timer_reload   = reload_q;
  assign result_o.timer_enabled  = tmr_q;
  assign result_o.busy_res       = run_q;
  assign result_o.driver_enabled = en_q;
  assign result_o.direction      = dir_q;
  assign result_o.step_level     = pin_q;

endmodule
